>>> hw/rtl/lrsa_pkg.sv
// lrsa_pkg: shared types, field widths and codes for the label region statistics block
// no dependencies; used by the channel interfaces, the divider and the top level
`default_nettype none

package lrsa_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 37;
    localparam int COORD_W   = 10;
    localparam int LABEL_W   = 9;
    localparam int CHANNEL_W = 2;
    localparam int COUNT_W   = 21;

    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] MEAN_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] MEAN_MIN = 16'sh8000;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } position_t;

    typedef struct packed {
        logic                       seen;
        logic [SUM_W-1:0]           sum;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SAMPLE_W-1:0] max_value;
        position_t                  min_pos;
        position_t                  max_pos;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DIV,
        ST_HOLD
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/lrsa_channels.sv
// lrsa_in_if and lrsa_out_if: valid/ready channels for sample words and statistics words
// depends on lrsa_pkg for field widths
`default_nettype none

interface lrsa_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      kind;
    logic [lrsa_pkg::LABEL_W-1:0]              label;
    logic [lrsa_pkg::CHANNEL_W-1:0]            channel;
    logic [lrsa_pkg::COORD_W-1:0]              row;
    logic [lrsa_pkg::COORD_W-1:0]              col;
    logic signed [lrsa_pkg::SAMPLE_W-1:0]      sample;
    logic [lrsa_pkg::COUNT_W-1:0]              label_count;

    modport source (
        output valid, kind, label, channel, row, col, sample, label_count,
        input  ready
    );
    modport sink (
        input  valid, kind, label, channel, row, col, sample, label_count,
        output ready
    );
endinterface

interface lrsa_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [lrsa_pkg::SAMPLE_W-1:0]      mean_value;
    logic signed [lrsa_pkg::SAMPLE_W-1:0]      min_value;
    logic signed [lrsa_pkg::SAMPLE_W-1:0]      max_value;
    logic [lrsa_pkg::COORD_W-1:0]              min_row;
    logic [lrsa_pkg::COORD_W-1:0]              min_col;
    logic [lrsa_pkg::COORD_W-1:0]              max_row;
    logic [lrsa_pkg::COORD_W-1:0]              max_col;
    logic                                      region_empty;
    logic                                      count_zero;

    modport source (
        output valid, mean_value, min_value, max_value, min_row, min_col,
               max_row, max_col, region_empty, count_zero,
        input  ready
    );
    modport sink (
        input  valid, mean_value, min_value, max_value, min_row, min_col,
               max_row, max_col, region_empty, count_zero,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/lrsa_divider.sv
// lrsa_divider: bit-serial restoring divider, unsigned sum magnitude by unsigned count
// depends on lrsa_pkg; one quotient bit per cycle, done pulses in the cycle after the last step
`default_nettype none

module lrsa_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lrsa_pkg::SUM_W-1:0]      dividend,
    input  logic [lrsa_pkg::COUNT_W-1:0]    divisor,
    output logic                            done,
    output logic [lrsa_pkg::SUM_W-1:0]      quotient
);

    logic                               active_reg, active_next;
    logic                               done_reg, done_next;
    logic [lrsa_pkg::DIV_CNT_W-1:0]     step_reg, step_next;
    logic [lrsa_pkg::COUNT_W-1:0]       rem_reg, rem_next;
    logic [lrsa_pkg::SUM_W-1:0]         quo_reg, quo_next;
    logic [lrsa_pkg::COUNT_W-1:0]       dsr_reg, dsr_next;

    logic [lrsa_pkg::COUNT_W:0]         shifted;
    logic [lrsa_pkg::COUNT_W+1:0]       diff;
    logic                               fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[lrsa_pkg::SUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dsr_reg};
        fits    = !diff[lrsa_pkg::COUNT_W+1];
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dsr_next    = dsr_reg;
        if (start)
        begin
            active_next = 1'b1;
            step_next   = '0;
            rem_next    = '0;
            quo_next    = dividend;
            dsr_next    = divisor;
        end
        else if (active_reg)
        begin
            rem_next  = fits ? diff[lrsa_pkg::COUNT_W-1:0] : shifted[lrsa_pkg::COUNT_W-1:0];
            quo_next  = {quo_reg[lrsa_pkg::SUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == lrsa_pkg::DIV_LAST_STEP)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/label_region_stats_accumulator.sv
// Per-label, per-channel region statistics (sum, min, max, first extreme positions) kept in one
// entry memory of NUM_LABELS*NUM_CHANNELS words; a readout word returns the entry and clears it.
// Pixel words are taken one per cycle while no readout holds the input: the entry is read at
// acceptance and written back in the following cycle, with the last written entry forwarded
// to the next word. A readout blocks input while the bit-serial mean divider runs its 37 steps
// and hands off the mean, or only through the hold state for an empty entry or zero count,
// longer if the result side stalls. After reset a clearing pass writes every entry before any
// word is accepted. Depends on lrsa_pkg, lrsa_channels and lrsa_divider.
`default_nettype none

module label_region_stats_accumulator #(
    parameter int NUM_LABELS   = 256,
    parameter int NUM_CHANNELS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    lrsa_in_if.sink       items,
    lrsa_out_if.source    results
);

    localparam int NUM_ENTRIES = NUM_LABELS * NUM_CHANNELS;
    localparam int ADDR_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_ENTRIES - 1);
    localparam int SUM_W    = lrsa_pkg::SUM_W;
    localparam int SAMPLE_W = lrsa_pkg::SAMPLE_W;

    lrsa_pkg::entry_t mem [NUM_ENTRIES];

    lrsa_pkg::state_t           state_reg, state_next;
    logic [ADDR_W-1:0]          clr_addr_reg, clr_addr_next;

    logic                       in_accept;
    logic                       in_addr_ok;
    logic [31:0]                in_addr_full;
    logic [ADDR_W-1:0]          in_addr;

    lrsa_pkg::entry_t           rd_data_reg;

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_kind_reg;
    logic                       s1_addr_ok_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    lrsa_pkg::position_t        s1_pos_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [lrsa_pkg::COUNT_W-1:0] s1_count_reg;

    logic                       wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0]          wb_addr_reg;
    lrsa_pkg::entry_t           wb_data_reg;

    lrsa_pkg::entry_t           cur_entry;
    lrsa_pkg::entry_t           upd_entry;
    logic [SUM_W-1:0]           sample_ext;

    logic                       item_we;
    lrsa_pkg::entry_t           item_wdata;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    lrsa_pkg::entry_t           mem_wdata;

    logic                       readout_now;
    logic                       rd_empty;
    logic                       rd_count_zero;
    logic                       div_start;
    logic [SUM_W-1:0]           div_dividend;
    logic                       div_done;
    logic [SUM_W-1:0]           div_quotient;
    logic signed [SAMPLE_W-1:0] sat_mean;

    logic signed [SAMPLE_W-1:0] res_mean_reg;
    logic signed [SAMPLE_W-1:0] res_min_reg;
    logic signed [SAMPLE_W-1:0] res_max_reg;
    lrsa_pkg::position_t        res_min_pos_reg;
    lrsa_pkg::position_t        res_max_pos_reg;
    logic                       res_empty_reg;
    logic                       res_count_zero_reg;
    logic                       res_neg_reg;

    logic                       out_free;
    logic                       out_load;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_mean_reg;
    logic signed [SAMPLE_W-1:0] out_min_reg;
    logic signed [SAMPLE_W-1:0] out_max_reg;
    lrsa_pkg::position_t        out_min_pos_reg;
    lrsa_pkg::position_t        out_max_pos_reg;
    logic                       out_empty_reg;
    logic                       out_count_zero_reg;

    // input address decode
    always_comb
    begin
        in_addr_ok = (items.label != '0) && (32'(items.label) <= NUM_LABELS) &&
                     (32'(items.channel) < NUM_CHANNELS);
        in_addr_full = (32'(items.label) - 32'd1) * NUM_CHANNELS + 32'(items.channel);
        in_addr = in_addr_ok ? in_addr_full[ADDR_W-1:0] : '0;
    end

    assign in_accept = items.valid && items.ready;

    // entry memory
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[in_addr];
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // entry seen by the word in the update stage
    always_comb
    begin
        cur_entry = (wb_valid_reg && (wb_addr_reg == s1_addr_reg)) ? wb_data_reg : rd_data_reg;
        sample_ext = {{(SUM_W - SAMPLE_W){s1_sample_reg[SAMPLE_W-1]}}, s1_sample_reg};
    end

    always_comb
    begin
        upd_entry = cur_entry;
        if (!cur_entry.seen)
        begin
            upd_entry.seen      = 1'b1;
            upd_entry.sum       = sample_ext;
            upd_entry.min_value = s1_sample_reg;
            upd_entry.max_value = s1_sample_reg;
            upd_entry.min_pos   = s1_pos_reg;
            upd_entry.max_pos   = s1_pos_reg;
        end
        else
        begin
            upd_entry.sum = cur_entry.sum + sample_ext;
            if (s1_sample_reg < cur_entry.min_value)
            begin
                upd_entry.min_value = s1_sample_reg;
                upd_entry.min_pos   = s1_pos_reg;
            end
            if (s1_sample_reg > cur_entry.max_value)
            begin
                upd_entry.max_value = s1_sample_reg;
                upd_entry.max_pos   = s1_pos_reg;
            end
        end
    end

    // write port: clearing pass or update stage
    always_comb
    begin
        item_we    = s1_valid_reg && s1_addr_ok_reg;
        item_wdata = (s1_kind_reg == lrsa_pkg::KIND_PIXEL) ? upd_entry : '0;
        mem_we     = (state_reg == lrsa_pkg::ST_CLEAR) || item_we;
        mem_waddr  = (state_reg == lrsa_pkg::ST_CLEAR) ? clr_addr_reg : s1_addr_reg;
        mem_wdata  = (state_reg == lrsa_pkg::ST_CLEAR) ? '0 : item_wdata;
        wb_valid_next = item_we;
    end

    // readout handling
    always_comb
    begin
        readout_now   = s1_valid_reg && (s1_kind_reg == lrsa_pkg::KIND_READOUT);
        rd_empty      = !s1_addr_ok_reg || !cur_entry.seen;
        rd_count_zero = (s1_count_reg == '0);
        div_start     = readout_now && !rd_empty && !rd_count_zero;
        div_dividend  = cur_entry.sum[SUM_W-1] ? (~cur_entry.sum + 1'b1) : cur_entry.sum;
    end

    lrsa_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (s1_count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // saturate the signed quotient to the sample range
    always_comb
    begin
        if (res_neg_reg)
        begin
            if (div_quotient > SUM_W'(32768))
            begin
                sat_mean = lrsa_pkg::MEAN_MIN;
            end
            else
            begin
                sat_mean = SAMPLE_W'(~div_quotient + 1'b1);
            end
        end
        else
        begin
            if (div_quotient > SUM_W'(32767))
            begin
                sat_mean = lrsa_pkg::MEAN_MAX;
            end
            else
            begin
                sat_mean = div_quotient[SAMPLE_W-1:0];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrsa_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = lrsa_pkg::ST_RUN;
                end
            end
            lrsa_pkg::ST_RUN:
            begin
                if (readout_now)
                begin
                    state_next = div_start ? lrsa_pkg::ST_DIV : lrsa_pkg::ST_HOLD;
                end
            end
            lrsa_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = lrsa_pkg::ST_HOLD;
                end
            end
            lrsa_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = lrsa_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = lrsa_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        out_free      = !out_valid_reg || results.ready;
        items.ready   = (state_reg == lrsa_pkg::ST_RUN) && !readout_now;
        out_load      = (state_reg == lrsa_pkg::ST_HOLD) && out_free;
        clr_addr_next = (state_reg == lrsa_pkg::ST_CLEAR) ? clr_addr_reg + 1'b1 : clr_addr_reg;
        s1_valid_next = in_accept;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrsa_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg    <= items.kind;
            s1_addr_ok_reg <= in_addr_ok;
            s1_addr_reg    <= in_addr;
            s1_pos_reg     <= '{row: items.row, col: items.col};
            s1_sample_reg  <= items.sample;
            s1_count_reg   <= items.label_count;
        end
        if (item_we)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_data_reg <= item_wdata;
        end
        if (readout_now)
        begin
            res_mean_reg       <= '0;
            res_min_reg        <= rd_empty ? '0 : cur_entry.min_value;
            res_max_reg        <= rd_empty ? '0 : cur_entry.max_value;
            res_min_pos_reg    <= rd_empty ? '0 : cur_entry.min_pos;
            res_max_pos_reg    <= rd_empty ? '0 : cur_entry.max_pos;
            res_empty_reg      <= rd_empty;
            res_count_zero_reg <= rd_count_zero;
            res_neg_reg        <= cur_entry.sum[SUM_W-1];
        end
        else if (div_done)
        begin
            res_mean_reg <= sat_mean;
        end
        if (out_load)
        begin
            out_mean_reg       <= res_mean_reg;
            out_min_reg        <= res_min_reg;
            out_max_reg        <= res_max_reg;
            out_min_pos_reg    <= res_min_pos_reg;
            out_max_pos_reg    <= res_max_pos_reg;
            out_empty_reg      <= res_empty_reg;
            out_count_zero_reg <= res_count_zero_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.mean_value   = out_mean_reg;
    assign results.min_value    = out_min_reg;
    assign results.max_value    = out_max_reg;
    assign results.min_row      = out_min_pos_reg.row;
    assign results.min_col      = out_min_pos_reg.col;
    assign results.max_row      = out_max_pos_reg.row;
    assign results.max_col      = out_max_pos_reg.col;
    assign results.region_empty = out_empty_reg;
    assign results.count_zero   = out_count_zero_reg;

    // divider finishes only while a readout is waiting on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == lrsa_pkg::ST_DIV))
        else $error("divider done outside divide state");

    // a readout in the update stage closes the input on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        readout_now |=> !items.ready)
        else $error("input open right after a readout");

    // a new result word comes only from the hold state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> ($past(state_reg) == lrsa_pkg::ST_HOLD))
        else $error("result word raised outside hold state");

    // no word enters while the clearing pass runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrsa_pkg::ST_CLEAR) |-> (!items.ready && !s1_valid_reg))
        else $error("word accepted during clearing pass");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench for label_region_stats_accumulator: directed and random pixel and readout words,
// checked against a per-entry statistics predictor kept in the bench
// depends on lrsa_pkg, lrsa_channels and the block itself
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LABELS   = 256;
    localparam int NUM_CHANNELS = 4;
    localparam int NUM_ENTRIES  = NUM_LABELS * NUM_CHANNELS;
    localparam int STALL_LIMIT  = 6000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;

    localparam int SAMPLE_W  = lrsa_pkg::SAMPLE_W;
    localparam int SUM_W     = lrsa_pkg::SUM_W;
    localparam int COORD_W   = lrsa_pkg::COORD_W;
    localparam int LABEL_W   = lrsa_pkg::LABEL_W;
    localparam int CHANNEL_W = lrsa_pkg::CHANNEL_W;
    localparam int COUNT_W   = lrsa_pkg::COUNT_W;

    typedef struct packed {
        logic                       kind;
        logic [LABEL_W-1:0]         label;
        logic [CHANNEL_W-1:0]       channel;
        logic [COORD_W-1:0]         row;
        logic [COORD_W-1:0]         col;
        logic signed [SAMPLE_W-1:0] sample;
        logic [COUNT_W-1:0]         label_count;
    } sample_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_value;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SAMPLE_W-1:0] max_value;
        logic [COORD_W-1:0]         min_row;
        logic [COORD_W-1:0]         min_col;
        logic [COORD_W-1:0]         max_row;
        logic [COORD_W-1:0]         max_col;
        logic                       region_empty;
        logic                       count_zero;
    } stats_word_t;

    logic clk = 1'b0;
    logic rst_n;

    lrsa_in_if  sample_ch ();
    lrsa_out_if stats_ch ();

    label_region_stats_accumulator #(
        .NUM_LABELS   (NUM_LABELS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (sample_ch),
        .results (stats_ch)
    );

    lrsa_pkg::entry_t region_mem [NUM_ENTRIES];
    stats_word_t      pending_stats [$];
    int               stat_errors = 0;
    int               stall_cycles = 0;
    int               hold_left = 0;
    int               hold_requests = 0;
    int               holds_started = 0;
    logic             gaps_on;

    always #5 clk = ~clk;

    function automatic void predict_region_stats(input sample_word_t w);
        int               idx;
        logic             in_range;
        lrsa_pkg::entry_t ent;
        stats_word_t      res;
        longint           total;
        longint           quot;
        in_range = (w.label != 0) && (int'(w.label) <= NUM_LABELS)
                   && (int'(w.channel) < NUM_CHANNELS);
        idx = (int'(w.label) - 1) * NUM_CHANNELS + int'(w.channel);
        if (w.kind == lrsa_pkg::KIND_PIXEL)
        begin
            if (!in_range)
                return;
            ent = region_mem[idx];
            if (!ent.seen)
            begin
                ent.seen = 1'b1;
                ent.min_value = w.sample;
                ent.max_value = w.sample;
                ent.min_pos = '{row: w.row, col: w.col};
                ent.max_pos = '{row: w.row, col: w.col};
            end
            else
            begin
                if (w.sample < ent.min_value)
                begin
                    ent.min_value = w.sample;
                    ent.min_pos = '{row: w.row, col: w.col};
                end
                if (w.sample > ent.max_value)
                begin
                    ent.max_value = w.sample;
                    ent.max_pos = '{row: w.row, col: w.col};
                end
            end
            ent.sum = ent.sum + {{(SUM_W-SAMPLE_W){w.sample[SAMPLE_W-1]}}, w.sample};
            region_mem[idx] = ent;
            return;
        end
        res = '0;
        res.count_zero = (w.label_count == 0);
        if (!in_range || !region_mem[idx].seen)
        begin
            res.region_empty = 1'b1;
            if (in_range)
                region_mem[idx] = '0;
        end
        else
        begin
            ent = region_mem[idx];
            if (w.label_count != 0)
            begin
                total = longint'($signed(ent.sum));
                quot = total / longint'(w.label_count);
                if (quot > 32767)
                    quot = 32767;
                if (quot < -32768)
                    quot = -32768;
                res.mean_value = SAMPLE_W'(quot);
            end
            res.min_value = ent.min_value;
            res.max_value = ent.max_value;
            res.min_row = ent.min_pos.row;
            res.min_col = ent.min_pos.col;
            res.max_row = ent.max_pos.row;
            res.max_col = ent.max_pos.col;
            region_mem[idx] = '0;
        end
        pending_stats.push_back(res);
    endfunction

    function automatic string format_stats(input stats_word_t s);
        return $sformatf({"mean %0d min %0d max %0d min_at (%0d,%0d) max_at (%0d,%0d) ",
                          "empty %0b zero %0b"},
                         s.mean_value, s.min_value, s.max_value, s.min_row, s.min_col,
                         s.max_row, s.max_col, s.region_empty, s.count_zero);
    endfunction

    task automatic send_word(input sample_word_t w);
        while (gaps_on && $urandom_range(0, 99) < 25)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.kind = w.kind;
        sample_ch.label = w.label;
        sample_ch.channel = w.channel;
        sample_ch.row = w.row;
        sample_ch.col = w.col;
        sample_ch.sample = w.sample;
        sample_ch.label_count = w.label_count;
        sample_ch.valid = 1'b1;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
        predict_region_stats(w);
        @(negedge clk);
    endtask

    task automatic send_pixel(input int label, input int channel, input int row, input int col,
                              input int sample);
        sample_word_t w;
        w.kind = lrsa_pkg::KIND_PIXEL;
        w.label = LABEL_W'(label);
        w.channel = CHANNEL_W'(channel);
        w.row = COORD_W'(row);
        w.col = COORD_W'(col);
        w.sample = SAMPLE_W'(sample);
        w.label_count = COUNT_W'($urandom);
        send_word(w);
    endtask

    task automatic send_readout(input int label, input int channel, input int count);
        sample_word_t w;
        w.kind = lrsa_pkg::KIND_READOUT;
        w.label = LABEL_W'(label);
        w.channel = CHANNEL_W'(channel);
        w.row = COORD_W'($urandom);
        w.col = COORD_W'($urandom);
        w.sample = SAMPLE_W'($urandom);
        w.label_count = COUNT_W'(count);
        send_word(w);
    endtask

    function automatic int pick_label();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 6);
        else if (r < 95)
            return $urandom_range(250, NUM_LABELS);
        return $urandom_range(1, NUM_LABELS);
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        else if (r < 20)
            return int'(COUNT_W'($urandom));
        else if (r < 30)
            return 1;
        return $urandom_range(2, 40);
    endfunction

    function automatic int pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return int'($urandom_range(0, 6)) - 3;
        else if (r < 25)
            return -32768;
        else if (r < 30)
            return 32767;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic test_directed_cases();
        send_readout(5, 0, 10);
        send_pixel(0, 1, 3, 4, 16'h1234);
        send_readout(0, 1, 0);
        send_pixel(257, 2, 7, 8, 500);
        send_readout(257, 2, 3);
        send_readout(511, 3, 2097151);
        send_pixel(1, 0, 1023, 0, -32768);
        send_pixel(1, 0, 0, 1023, 32767);
        send_pixel(1, 0, 5, 5, -32768);
        send_pixel(1, 0, 6, 6, 32767);
        send_readout(1, 0, 1);
        send_readout(1, 0, 1);
        send_pixel(256, 3, 10, 20, 32767);
        send_pixel(256, 3, 11, 21, 32767);
        send_pixel(256, 3, 12, 22, 32767);
        send_readout(256, 3, 1);
        send_pixel(2, 1, 1023, 1023, -32768);
        send_pixel(2, 1, 512, 256, -32768);
        send_readout(2, 1, 1);
        send_pixel(3, 2, 341, 682, 100);
        send_readout(3, 2, 0);
        send_pixel(4, 0, 100, 200, -7);
        send_pixel(4, 0, 101, 201, 0);
        send_readout(4, 0, 2);
        send_readout(4, 0, 1048576);
    endtask

    task automatic test_random_images(input int n_words);
        sample_word_t w;
        int           r;
        repeat (n_words)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                w.kind = $urandom_range(0, 3) == 0 ? lrsa_pkg::KIND_READOUT
                                                   : lrsa_pkg::KIND_PIXEL;
                w.label = LABEL_W'($urandom);
                w.channel = CHANNEL_W'($urandom);
                w.row = COORD_W'($urandom);
                w.col = COORD_W'($urandom);
                w.sample = SAMPLE_W'($urandom);
                w.label_count = COUNT_W'($urandom);
                send_word(w);
            end
            else if (r < 20)
                send_readout(pick_label(), $urandom_range(0, NUM_CHANNELS - 1), pick_count());
            else
                send_pixel(pick_label(), $urandom_range(0, NUM_CHANNELS - 1),
                           $urandom_range(0, 1023), $urandom_range(0, 1023), pick_sample());
        end
    endtask

    task automatic test_output_backpressure();
        hold_requests++;
        repeat (80)
        begin
            if ($urandom_range(0, 4) == 0)
                send_readout($urandom_range(1, 6), $urandom_range(0, NUM_CHANNELS - 1),
                             pick_count());
            else
                send_pixel($urandom_range(1, 6), $urandom_range(0, NUM_CHANNELS - 1),
                           $urandom_range(0, 1023), $urandom_range(0, 1023), pick_sample());
        end
    endtask

    // receiver side: random stalls, plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_requests != holds_started)
        begin
            holds_started = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            stats_ch.ready = 1'b0;
            hold_left--;
        end
        else
            stats_ch.ready = !gaps_on || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge clk)
    begin
        stats_word_t got;
        stats_word_t exp;
        if (rst_n && stats_ch.valid === 1'b1 && stats_ch.ready === 1'b1)
        begin
            got = '{mean_value: stats_ch.mean_value, min_value: stats_ch.min_value,
                    max_value: stats_ch.max_value, min_row: stats_ch.min_row,
                    min_col: stats_ch.min_col, max_row: stats_ch.max_row,
                    max_col: stats_ch.max_col, region_empty: stats_ch.region_empty,
                    count_zero: stats_ch.count_zero};
            if (pending_stats.size() == 0)
            begin
                if (stat_errors < 10)
                    $display("unexpected stats word: %s", format_stats(got));
                stat_errors++;
            end
            else
            begin
                exp = pending_stats.pop_front();
                if (got.mean_value !== exp.mean_value || got.min_value !== exp.min_value
                    || got.max_value !== exp.max_value || got.min_row !== exp.min_row
                    || got.min_col !== exp.min_col || got.max_row !== exp.max_row
                    || got.max_col !== exp.max_col || got.region_empty !== exp.region_empty
                    || got.count_zero !== exp.count_zero)
                begin
                    if (stat_errors < 10)
                    begin
                        $display("stats mismatch at %0t", $realtime);
                        $display("  expected %s", format_stats(exp));
                        $display("  actual   %s", format_stats(got));
                    end
                    stat_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
            || (stats_ch.valid === 1'b1 && stats_ch.ready === 1'b1))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.kind = lrsa_pkg::KIND_PIXEL;
        sample_ch.label = '0;
        sample_ch.channel = '0;
        sample_ch.row = '0;
        sample_ch.col = '0;
        sample_ch.sample = '0;
        sample_ch.label_count = '0;
        gaps_on = 1'b1;
        foreach (region_mem[i])
            region_mem[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_random_images(250);
        gaps_on = 1'b0;
        test_random_images(150);
        gaps_on = 1'b1;
        test_output_backpressure();
        test_random_images(200);

        sample_ch.valid = 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (stat_errors == 0 && pending_stats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
